FILE: rtl/socd_pkg.sv
// Shared types and constants for the opposing-key resolver.
package socd_pkg;

   localparam int KeyWidth   = 3;
   localparam int MaskWidth  = 4;
   localparam int CsrAddrW   = 3;
   localparam int CsrDataW   = 32;

   // Key codes carried by key_select
   localparam logic [KeyWidth-1:0] KeyLeft   = 3'd0;
   localparam logic [KeyWidth-1:0] KeyRight  = 3'd1;
   localparam logic [KeyWidth-1:0] KeyUp     = 3'd2;
   localparam logic [KeyWidth-1:0] KeyDown   = 3'd3;
   localparam logic [KeyWidth-1:0] KeyToggle = 3'd4;

   // Opposite action codes
   localparam logic [1:0] ActNone    = 2'd0;
   localparam logic [1:0] ActRelease = 2'd1;
   localparam logic [1:0] ActPress   = 2'd2;

   // Register indexes (paddr[2])
   localparam logic RegPriority = 1'b0;
   localparam logic RegNullify  = 1'b1;

   localparam logic [MaskWidth-1:0] PriorityReset = 4'd4;
   localparam logic [MaskWidth-1:0] NullifyReset  = 4'd8;

   typedef struct packed {
      logic [MaskWidth-1:0] priority_mask;
      logic [MaskWidth-1:0] nullify_mask;
   } cfg_type;

   typedef struct packed {
      logic [KeyWidth-1:0] key_select;
      logic                is_press;
   } req_type;

   typedef struct packed {
      logic       pass_event;
      logic [1:0] opposite_action;
      logic [1:0] opposite_key;
      logic       mode_on;
   } rsp_type;

endpackage

FILE: rtl/socd_csr.sv
// APB register file holding the priority and nullify masks.
module socd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [socd_pkg::CsrAddrW-1:0] paddr,
   input  logic [socd_pkg::CsrDataW-1:0] pwdata,
   output logic [socd_pkg::CsrDataW-1:0] prdata,
   output logic                          pready,
   output socd_pkg::cfg_type             cfg
);
   import socd_pkg::*;

   logic [MaskWidth-1:0] priority_ff, priority_in;
   logic [MaskWidth-1:0] nullify_ff, nullify_in;
   logic                 wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      priority_in = priority_ff;
      nullify_in  = nullify_ff;
      if (wr_en) begin
         unique case (paddr[2])
            RegPriority: priority_in = pwdata[MaskWidth-1:0];
            RegNullify:  nullify_in  = pwdata[MaskWidth-1:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         priority_ff <= PriorityReset;
         nullify_ff  <= NullifyReset;
      end else begin
         priority_ff <= priority_in;
         nullify_ff  <= nullify_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         RegPriority: prdata[MaskWidth-1:0] = priority_ff;
         RegNullify:  prdata[MaskWidth-1:0] = nullify_ff;
         default:     ;
      endcase
   end

   assign cfg.priority_mask = priority_ff;
   assign cfg.nullify_mask  = nullify_ff;

endmodule

FILE: rtl/socd_core.sv
// Key state registers and the combinational resolution logic.
module socd_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  socd_pkg::req_type req,
   input  socd_pkg::cfg_type cfg,
   output socd_pkg::rsp_type rsp
);
   import socd_pkg::*;

   logic [MaskWidth-1:0] held_ff, held_in;
   logic [MaskWidth-1:0] sent_ff, sent_in;
   logic                 mode_ff, mode_in;

   logic [MaskWidth-1:0] kb, ob;
   logic [1:0]           opp;
   logic                 done;

   assign opp = req.key_select[1:0] ^ 2'b01;

   always_comb begin
      kb   = '0;
      ob   = '0;
      kb[req.key_select[1:0]] = 1'b1;
      ob[opp]                 = 1'b1;
      held_in = held_ff;
      sent_in = sent_ff;
      mode_in = mode_ff;
      done    = 1'b0;
      rsp.pass_event      = 1'b1;
      rsp.opposite_action = ActNone;
      rsp.opposite_key    = 2'd0;
      if (req.key_select == KeyToggle) begin
         if (req.is_press) mode_in = ~mode_ff;
         rsp.pass_event = 1'b0;
      end else if (req.key_select < KeyToggle) begin
         rsp.opposite_key = opp;
         if (mode_ff) begin
            if (req.is_press) begin
               held_in = held_ff | kb;
               if ((sent_ff & ob) != '0) begin
                  if ((cfg.priority_mask & ob) == '0) begin
                     sent_in = sent_in & ~ob;
                     rsp.opposite_action = ActRelease;
                  end
                  if ((cfg.nullify_mask & kb) != '0) begin
                     sent_in = sent_in & ~kb;
                     rsp.pass_event = 1'b0;
                     done = 1'b1;
                  end
               end
               if (!done) sent_in = sent_in | kb;
            end else begin
               held_in = held_ff & ~kb;
               // opposite still held but released earlier: press it again
               if (((held_in & ob) != '0) && ((sent_ff & ob) == '0)) begin
                  sent_in = sent_in | ob;
                  rsp.opposite_action = ActPress;
               end
               if (((cfg.nullify_mask & kb) != '0) && ((sent_ff & kb) == '0)) begin
                  rsp.pass_event = 1'b0;
                  done = 1'b1;
               end
               if (!done) sent_in = sent_in & ~kb;
            end
         end
      end
      rsp.mode_on = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         sent_ff <= '0;
         mode_ff <= 1'b0;
      end else if (advance) begin
         held_ff <= held_in;
         sent_ff <= sent_in;
         mode_ff <= mode_in;
      end
   end

endmodule

FILE: rtl/opposing_key_socd_resolver.sv
// Top level of the opposing-key resolver: request/response pipeline and APB port.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_key_select[2:0], req_is_press
//   rsp       out        rsp_valid/rsp_ready  rsp_pass_event, rsp_opposite_action[1:0],
//                                             rsp_opposite_key[1:0], rsp_mode_on
//   csr       in/out     psel/penable/pready  paddr[2:0], pwdata, prdata (masks at 0x0, 0x4)
//
// One request per clock sustained while rsp_ready stays high; rsp_valid rises once an accepted
// request has passed the input register, then resolve logic into the response register.
// Synchronous active-high reset clears the valid bits, the held/sent flags and
// the mode; masks reset to priority 0x4 and nullify 0x8.
// A stalled response holds the response register; the input register still
// takes a request when it is empty, then req_ready drops until rsp moves.
module opposing_key_socd_resolver (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [socd_pkg::KeyWidth-1:0] req_key_select,
   input  logic                          req_is_press,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_pass_event,
   output logic [1:0]                    rsp_opposite_action,
   output logic [1:0]                    rsp_opposite_key,
   output logic                          rsp_mode_on,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [socd_pkg::CsrAddrW-1:0] paddr,
   input  logic [socd_pkg::CsrDataW-1:0] pwdata,
   output logic [socd_pkg::CsrDataW-1:0] prdata,
   output logic                          pready
);
   import socd_pkg::*;

   cfg_type cfg;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_comb;
   logic    in_valid_ff, in_valid_in;
   logic    out_valid_ff, out_valid_in;
   logic    advance;

   socd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Input register moves into the response register when that one is free
   // or being emptied this cycle; the key state updates on the same edge.
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   assign req_in.key_select = req_key_select;
   assign req_in.is_press   = req_is_press;

   socd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_comb)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_ready) in_valid_in = req_valid;
      if (advance) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid & req_ready) req_ff <= req_in;
      if (advance) rsp_ff <= rsp_comb;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_pass_event      = rsp_ff.pass_event;
   assign rsp_opposite_action = rsp_ff.opposite_action;
   assign rsp_opposite_key    = rsp_ff.opposite_key;
   assign rsp_mode_on         = rsp_ff.mode_on;

endmodule
